// ===== src/fk6_pkg.sv =====
`default_nettype none

package fk6_pkg;

	// Counts of joints and links.
	localparam int NJ = 6;
	localparam int NL = 5;

	// Field widths at the ports.
	localparam int AW  = 16;
	localparam int LW  = 20;
	localparam int RW  = 16;
	localparam int OPW = 24;

	// Internal widths: CORDIC datapath, Q24 trig, Q24 matrix, products, position.
	localparam int ZW  = 33;
	localparam int XW  = 33;
	localparam int CW  = 26;
	localparam int MW  = 27;
	localparam int TPW = CW + MW;
	localparam int LPW = MW + LW + 1;
	localparam int PW  = 52;

	// CORDIC schedule.
	localparam int ITERS           = 24;
	localparam int ITERS_PER_STAGE = 4;
	localparam int IT_STAGES       = ITERS / ITERS_PER_STAGE;

	localparam logic signed [ZW:0]   HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [ZW:0]   PI_Q30      = 34'sd3373259426;
	localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;

	localparam logic signed [ZW-1:0] ATAN_Q30 [ITERS] = '{
		33'sh03243F6A8, 33'sh01DAC6705, 33'sh00FADBAFC, 33'sh007F56EA6,
		33'sh003FEAB76, 33'sh001FFD55B, 33'sh000FFFAAA, 33'sh0007FFF55,
		33'sh0003FFFEA, 33'sh0001FFFFD, 33'sh0000FFFFF, 33'sh00007FFFF,
		33'sh00003FFFF, 33'sh00001FFFF, 33'sh00000FFFF, 33'sh000007FFF,
		33'sh000003FFF, 33'sh000001FFF, 33'sh000000FFF, 33'sh0000007FF,
		33'sh0000003FF, 33'sh0000001FF, 33'sh0000000FF, 33'sh00000007F
	};

	localparam logic signed [MW-1:0] ONE_Q24   = 27'sd16777216;
	localparam logic signed [TPW+1:0] HALF_Q24 = 55'sd8388608;

	localparam logic signed [RW-1:0]  ROT_LIMIT = 16'sd16384;
	localparam logic signed [OPW-1:0] POS_LIMIT = 24'sd5242880;

	// Columns that each joint rotation mixes, and the column each link follows.
	localparam int TURN_P [NJ]   = '{0, 2, 2, 1, 2, 1};
	localparam int TURN_Q [NJ]   = '{1, 0, 0, 2, 0, 2};
	localparam int LINK_COL [NL] = '{2, 2, 2, 0, 0};

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		CFG_BASE_HEIGHT = 3'd0,
		CFG_UPPER_ARM   = 3'd1,
		CFG_ELBOW       = 3'd2,
		CFG_FOREARM     = 3'd3,
		CFG_WRIST       = 3'd4
	} cfg_reg_t;

	localparam logic [LW-1:0] LEN_RESET [NL] = '{
		20'd290000, 20'd270000, 20'd70000, 20'd302000, 20'd72000
	};

	typedef logic [NJ-1:0][AW-1:0]     angles_t;
	typedef logic [NJ-1:0][CW-1:0]     trig_t;
	typedef logic [2:0][2:0][MW-1:0]   mat_t;
	typedef logic [2:0][PW-1:0]        vec_t;
	typedef logic [NL-1:0][LW-1:0]     lens_t;

	typedef struct packed {
		trig_t c;
		trig_t s;
	} sincos_t;

	typedef struct packed {
		mat_t                     m;
		vec_t                     pos;
		logic [2:0][LPW-1:0]      lp;
		logic [2:0][3:0][TPW-1:0] tp;
		trig_t                    c;
		trig_t                    s;
	} chain_t;

endpackage

`default_nettype wire

// ===== src/fk6_cordic.sv =====
`default_nettype none

module fk6_cordic (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire fk6_pkg::angles_t  angles,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output fk6_pkg::sincos_t       sc
);

	localparam int NS = fk6_pkg::IT_STAGES + 2;
	localparam int NJ = fk6_pkg::NJ;
	localparam int XW = fk6_pkg::XW;
	localparam int ZW = fk6_pkg::ZW;
	localparam int CW = fk6_pkg::CW;
	localparam int IS = fk6_pkg::IT_STAGES;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] en;

	logic [NJ-1:0][XW-1:0] x_s [0:IS];
	logic [NJ-1:0][XW-1:0] y_s [0:IS];
	logic [NJ-1:0][ZW-1:0] z_s [0:IS];
	logic [NJ-1:0]         neg_s [0:IS];
	fk6_pkg::sincos_t      sc_s;

	// A stage loads when it is empty or its contents move on.
	always_comb begin
		en[NS-1] = !vld_s[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[NS-1];
	assign sc        = sc_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Range reduction into plus or minus half pi; the sign flip is applied at the end.
	logic [NJ-1:0][ZW-1:0] z_d;
	logic [NJ-1:0]         neg_d;

	always_comb begin
		logic signed [ZW:0] zf;
		logic signed [ZW:0] zr;
		for (int j = 0; j < NJ; j++) begin
			zf = $signed({angles[j][fk6_pkg::AW-1], angles[j], 17'b0});
			zr = zf;
			neg_d[j] = 1'b0;
			if (zf > fk6_pkg::HALF_PI_Q30) begin
				zr = zf - fk6_pkg::PI_Q30;
				neg_d[j] = 1'b1;
			end else if (zf < -fk6_pkg::HALF_PI_Q30) begin
				zr = zf + fk6_pkg::PI_Q30;
				neg_d[j] = 1'b1;
			end
			z_d[j] = zr[ZW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < NJ; j++) begin
				x_s[0][j] <= fk6_pkg::GAIN_Q30;
				y_s[0][j] <= '0;
			end
			z_s[0]   <= z_d;
			neg_s[0] <= neg_d;
		end
	end

	// Rotation-mode iterations, a fixed group of them per stage.
	for (genvar k = 1; k <= IS; k++) begin : g_iter
		logic [NJ-1:0][XW-1:0] xn_c;
		logic [NJ-1:0][XW-1:0] yn_c;
		logic [NJ-1:0][ZW-1:0] zn_c;

		always_comb begin
			logic signed [XW-1:0] xt;
			logic signed [XW-1:0] yt;
			logic signed [XW-1:0] xn;
			logic signed [ZW-1:0] zt;
			int idx;
			for (int j = 0; j < NJ; j++) begin
				xt = x_s[k-1][j];
				yt = y_s[k-1][j];
				zt = z_s[k-1][j];
				for (int t = 0; t < fk6_pkg::ITERS_PER_STAGE; t++) begin
					idx = (k - 1) * fk6_pkg::ITERS_PER_STAGE + t;
					if (!zt[ZW-1]) begin
						xn = xt - (yt >>> idx);
						yt = yt + (xt >>> idx);
						zt = zt - fk6_pkg::ATAN_Q30[idx];
					end else begin
						xn = xt + (yt >>> idx);
						yt = yt - (xt >>> idx);
						zt = zt + fk6_pkg::ATAN_Q30[idx];
					end
					xt = xn;
				end
				xn_c[j] = xt;
				yn_c[j] = yt;
				zn_c[j] = zt;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				x_s[k]   <= xn_c;
				y_s[k]   <= yn_c;
				z_s[k]   <= zn_c;
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	// Undo the reduction and round Q30 to Q24.
	fk6_pkg::sincos_t sc_d;

	always_comb begin
		logic signed [XW:0] xv;
		logic signed [XW:0] yv;
		for (int j = 0; j < NJ; j++) begin
			xv = $signed(x_s[IS][j]);
			yv = $signed(y_s[IS][j]);
			if (neg_s[IS][j]) begin
				xv = -xv;
				yv = -yv;
			end
			xv = xv + 34'sd32;
			yv = yv + 34'sd32;
			sc_d.c[j] = xv[CW+5:6];
			sc_d.s[j] = yv[CW+5:6];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			sc_s <= sc_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/fk6_chain.sv =====
`default_nettype none

module fk6_chain (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire fk6_pkg::sincos_t sc,
	input  wire fk6_pkg::lens_t   lens,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output fk6_pkg::chain_t       res
);

	localparam int NJ = fk6_pkg::NJ;
	localparam int NS = 2 * NJ;
	localparam int MW = fk6_pkg::MW;
	localparam int TPW = fk6_pkg::TPW;

	logic [NS:1]     vld_s;
	logic [NS:1]     en;
	fk6_pkg::chain_t st_s [1:NS];
	fk6_pkg::chain_t init_c;

	// Stall chain from the output back to the input.
	always_comb begin
		en[NS] = !vld_s[NS] || out_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_s[NS];
	assign res       = st_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Identity rotation at the origin, with all joint sines and cosines.
	always_comb begin
		init_c     = '0;
		init_c.c   = sc.c;
		init_c.s   = sc.s;
		for (int r = 0; r < 3; r++) begin
			init_c.m[r][r] = fk6_pkg::ONE_Q24;
		end
	end

	// Each joint takes a product stage and a round stage; the link before it rides along.
	for (genvar j = 0; j < NJ; j++) begin : g_joint
		localparam int P = fk6_pkg::TURN_P[j];
		localparam int Q = fk6_pkg::TURN_Q[j];

		fk6_pkg::chain_t prv;
		fk6_pkg::chain_t mul_c;
		fk6_pkg::chain_t rnd_c;
		logic [2:0][fk6_pkg::LPW-1:0] lp_c;

		if (j == 0) begin : g_first
			assign prv  = init_c;
			assign lp_c = '0;
		end else begin : g_next
			localparam int LC = fk6_pkg::LINK_COL[j-1];
			assign prv = st_s[2*j];
			always_comb begin
				for (int r = 0; r < 3; r++) begin
					lp_c[r] = $signed(prv.m[r][LC]) * $signed({1'b0, lens[j-1]});
				end
			end
		end

		// Products of the two mixed columns with cosine and sine.
		always_comb begin
			logic signed [MW-1:0] a;
			logic signed [MW-1:0] b;
			logic signed [fk6_pkg::CW-1:0] cj;
			logic signed [fk6_pkg::CW-1:0] sj;
			mul_c = prv;
			cj = prv.c[j];
			sj = prv.s[j];
			for (int r = 0; r < 3; r++) begin
				a = prv.m[r][P];
				b = prv.m[r][Q];
				mul_c.tp[r][0] = cj * a;
				mul_c.tp[r][1] = sj * b;
				mul_c.tp[r][2] = cj * b;
				mul_c.tp[r][3] = sj * a;
			end
			mul_c.lp = lp_c;
		end

		always_ff @(posedge clk) begin
			if (en[2*j+1]) begin
				st_s[2*j+1] <= mul_c;
			end
		end

		// Sum, round to Q24, and add the link contribution to the position.
		always_comb begin
			logic signed [TPW+1:0] sp;
			logic signed [TPW+1:0] sq;
			rnd_c = st_s[2*j+1];
			for (int r = 0; r < 3; r++) begin
				sp = $signed(st_s[2*j+1].tp[r][0]) + $signed(st_s[2*j+1].tp[r][1])
					+ fk6_pkg::HALF_Q24;
				sq = $signed(st_s[2*j+1].tp[r][2]) - $signed(st_s[2*j+1].tp[r][3])
					+ fk6_pkg::HALF_Q24;
				rnd_c.m[r][P] = sp[MW+23:24];
				rnd_c.m[r][Q] = sq[MW+23:24];
				rnd_c.pos[r] = $signed(st_s[2*j+1].pos[r]) + $signed(st_s[2*j+1].lp[r]);
			end
		end

		always_ff @(posedge clk) begin
			if (en[2*j+2]) begin
				st_s[2*j+2] <= rnd_c;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/fk6_out.sv =====
`default_nettype none

module fk6_out (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire fk6_pkg::chain_t res,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [215:0]         out_data
);

	localparam int MW  = fk6_pkg::MW;
	localparam int PW  = fk6_pkg::PW;
	localparam int RW  = fk6_pkg::RW;
	localparam int OPW = fk6_pkg::OPW;

	logic         vld_s;
	logic [215:0] data_s;
	logic [215:0] data_d;
	logic         en;

	assign en        = !vld_s || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s;
	assign out_data  = data_s;

	// Round to the output scales and clamp.
	always_comb begin
		logic signed [MW:0]    rt;
		logic signed [MW-10:0] rq;
		logic signed [PW:0]    pt;
		logic signed [PW-24:0] pq;
		logic signed [RW-1:0]  rv;
		logic signed [OPW-1:0] pv;
		data_d = '0;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				rt = $signed(res.m[r][k]) + 28'sd512;
				rq = rt[MW:10];
				if (rq > fk6_pkg::ROT_LIMIT) begin
					rv = fk6_pkg::ROT_LIMIT;
				end else if (rq < -fk6_pkg::ROT_LIMIT) begin
					rv = -fk6_pkg::ROT_LIMIT;
				end else begin
					rv = rq[RW-1:0];
				end
				data_d[(r*3+k)*RW +: RW] = rv;
			end
		end
		for (int r = 0; r < 3; r++) begin
			pt = $signed(res.pos[r]) + 53'sd8388608;
			pq = pt[PW:24];
			if (pq > fk6_pkg::POS_LIMIT) begin
				pv = fk6_pkg::POS_LIMIT;
			end else if (pq < -fk6_pkg::POS_LIMIT) begin
				pv = -fk6_pkg::POS_LIMIT;
			end else begin
				pv = pq[OPW-1:0];
			end
			data_d[9*RW + r*OPW +: OPW] = pv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s <= data_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/six_axis_forward_kinematics_unit.sv =====
// Six-axis forward kinematics: joint angles in, rotation matrix and position out.
// Input stream s_axis carries six signed joint angles, radians times 8192.
// Output stream m_axis carries the nine rotation entries times 16384 and the
// end-effector position in micrometres, one result per request.
// The cfg channel writes the five link lengths (micrometres); cfg_ready is always
// high and writes to indexes past the last register are dropped. Write them only
// while no request is in flight.
// From input acceptance to m_axis_tvalid a request crosses 8 stages of sine and
// cosine (range reduction, six groups of four CORDIC iterations, rounding), two
// stages per joint for the matrix product chain, and one output rounding stage.
// One request per cycle unless m_axis_tready stalls; each stage has a valid bit.
// Reset clears all valid bits and loads the default link lengths.
// When m_axis_tready is low, results pile up in the empty stages ahead of the output,
// and s_axis_tready drops only when every stage holds a request.
`default_nettype none

module six_axis_forward_kinematics_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// joint1_angle, joint2_angle, ... joint6_angle, 16 bits each.
	input  wire logic [95:0]  s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz, rot_zx, rot_zy, rot_zz (16 bits
	// each), then pos_x, pos_y, pos_z (24 bits each).
	output logic [215:0]      m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [19:0]  cfg_data
);

	fk6_pkg::lens_t   lens_q;
	fk6_pkg::angles_t angles;
	fk6_pkg::sincos_t sc;
	fk6_pkg::chain_t  res;
	logic             sc_valid;
	logic             sc_ready;
	logic             res_valid;
	logic             res_ready;

	assign cfg_ready = 1'b1;

	// Link length registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fk6_pkg::NL; i++) begin
				lens_q[i] <= fk6_pkg::LEN_RESET[i];
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fk6_pkg::CFG_BASE_HEIGHT: lens_q[0] <= cfg_data;
				fk6_pkg::CFG_UPPER_ARM:   lens_q[1] <= cfg_data;
				fk6_pkg::CFG_ELBOW:       lens_q[2] <= cfg_data;
				fk6_pkg::CFG_FOREARM:     lens_q[3] <= cfg_data;
				fk6_pkg::CFG_WRIST:       lens_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign angles = s_axis_tdata;

	fk6_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.angles    (angles),
		.out_valid (sc_valid),
		.out_ready (sc_ready),
		.sc        (sc)
	);

	fk6_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sc_valid),
		.in_ready  (sc_ready),
		.sc        (sc),
		.lens      (lens_q),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.res       (res)
	);

	fk6_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.res       (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire
